>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property, clocked on rising edge, off while reset is low
`define RRTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication form of the above
`define RRTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/rrts_pkg.sv
// types and constants of the round-robin task scheduler
// no dependencies
package rrts_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam logic [7:0] SLICE_RESET = 8'd10;
    localparam logic [15:0] ID_RESET = 16'd1;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_YIELD   = 3'd1,
        OP_CREATE  = 3'd2,
        OP_EXIT    = 3'd3,
        OP_BLOCK   = 3'd4,
        OP_UNBLOCK = 3'd5
    } opcode_t;

    // running tasks keep the ready code, only free and blocked are ever tested
    typedef enum logic [1:0] {
        SS_FREE    = 2'd0,
        SS_READY   = 2'd1,
        SS_BLOCKED = 2'd3
    } slot_state_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NO_SLOT = 2'd1,
        STS_REFUSED = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] new_id;
        logic [3:0]  new_slot;
        logic [3:0]  run_slot;
        logic [3:0]  prev_slot;
        logic        switched;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

endpackage

>>> hw/rtl/rrts_slot_mem.sv
// slot state memory, registered read, valid bit per entry
// depends on rrts_pkg
module rrts_slot_mem #(
    parameter int SLOTS = rrts_pkg::TASK_SLOTS_DEF,
    parameter int SW    = $clog2(SLOTS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      we,
    input  logic [SW-1:0]             waddr,
    input  rrts_pkg::slot_state_t     wdata,
    input  logic [SW-1:0]             raddr,
    output rrts_pkg::slot_state_t     rdata
);
    import rrts_pkg::*;

    slot_state_t mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    slot_state_t rd_reg;
    logic rvld_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
            rvld_reg <= vld_reg[raddr];
        end
    end

    // never-written slots read as free
    assign rdata = rvld_reg ? rd_reg : SS_FREE;
endmodule

>>> hw/rtl/rrts_ready_fifo.sv
// ready queue of slot numbers in a memory, head read registered on request
// depends on rrts_pkg
module rrts_ready_fifo #(
    parameter int SLOTS = rrts_pkg::TASK_SLOTS_DEF,
    parameter int SW    = $clog2(SLOTS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rrts_pkg::fifo_ctl_t  ctl,
    input  logic [SW-1:0]        push_slot,
    input  logic                 rd_en,
    output logic [SW-1:0]        head_slot,
    output logic                 nonempty
);
    import rrts_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);
    localparam logic [CW-1:0] FULL = CW'(SLOTS);

    logic [SW-1:0] mem [SLOTS];
    logic [SW-1:0] head_reg, tail_reg, hd_q_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_after_pop;
    logic push_ok;

    assign count_after_pop = ctl.pop ? count_reg - CW'(1) : count_reg;
    assign push_ok = ctl.push && (count_after_pop != FULL);
    assign nonempty = (count_reg != '0);
    assign head_slot = hd_q_reg;

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[tail_reg] <= push_slot;
        end
        if (rd_en) begin
            hd_q_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (ctl.pop) begin
                head_reg <= (head_reg == LAST) ? '0 : head_reg + SW'(1);
            end
            if (push_ok) begin
                tail_reg <= (tail_reg == LAST) ? '0 : tail_reg + SW'(1);
            end
            count_reg <= count_after_pop + CW'(push_ok);
        end
    end
endmodule

>>> hw/rtl/round_robin_task_scheduler.sv
// flow: an event is registered at the input transfer and handled in an execute
//   state, or for create in a free-slot search from slot 1 that walks the slot state
//   memory one read per cycle; the result passes a result register into the output
//   register, and a new event is taken only after that; a held result stalls input
// reset: synchronous active-low aresetn; idle task runs, all slots free, queue empty,
//   slice length 10, id counter 1; no transfer is taken while reset is low
module round_robin_task_scheduler #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // event input: [2:0] opcode, [6:3] target_slot, [7] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // result: [1:0] status, [2] switched, [6:3] prev_slot, [10:7] run_slot,
    //         [14:11] new_slot, [30:15] new_id, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // slice_ticks write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import rrts_pkg::*;

    localparam int SW = $clog2(TASK_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_OUT} fsm_t;

    fsm_t state_reg, state_next;
    opcode_t op_reg;
    logic [3:0] tgt_reg;
    logic tgt_ok_reg;
    logic [SW-1:0] run_reg, run_next;
    logic [SW-1:0] scan_reg;
    logic [7:0] slice_reg, slice_next, slice_ticks_reg;
    logic [15:0] id_reg, id_next;
    result_t res_reg, res_next;
    logic m_tvalid_reg;
    result_t m_data_reg;

    // memory and queue hookup
    logic st_we;
    logic [SW-1:0] st_waddr, st_raddr;
    slot_state_t st_wdata, st_rdata;
    fifo_ctl_t fctl;
    logic [SW-1:0] push_slot, head_slot;
    logic nonempty;
    logic s_xfer;

    // scratch for the event logic
    logic disp, has_old, requeue, done;
    logic [SW-1:0] next_slot;
    logic [7:0] dec;
    logic found, last;

    assign s_xfer    = s_tvalid && s_tready;
    assign s_tready  = aresetn && (state_reg == S_IDLE);
    assign cfg_ready = aresetn;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, m_data_reg};

    // create starts the search at slot 1, every other event reads its target
    always_comb begin
        if (state_reg == S_IDLE) begin
            st_raddr = (opcode_t'(s_tdata[2:0]) == OP_CREATE) ? SW'(1) : SW'(s_tdata[6:3]);
        end else begin
            st_raddr = scan_reg + SW'(1);
        end
    end

    rrts_slot_mem #(.SLOTS(TASK_SLOTS), .SW(SW)) u_slot_mem (
        .aclk(aclk), .aresetn(aresetn),
        .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    // head is read at every input transfer so a pop has it in the next cycle
    rrts_ready_fifo #(.SLOTS(TASK_SLOTS), .SW(SW)) u_ready_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .ctl(fctl), .push_slot(push_slot),
        .rd_en(s_xfer), .head_slot(head_slot), .nonempty(nonempty)
    );

    always_comb begin
        disp       = 1'b0;
        has_old    = 1'b1;
        requeue    = 1'b0;
        st_we      = 1'b0;
        st_waddr   = run_reg;
        st_wdata   = SS_FREE;
        fctl       = '0;
        push_slot  = run_reg;
        run_next   = run_reg;
        slice_next = slice_reg;
        id_next    = id_reg;
        res_next   = '0;
        res_next.status = STS_OK;
        next_slot  = nonempty ? head_slot : '0;
        dec        = (slice_reg == '0) ? '0 : slice_reg - 8'd1;
        found      = (st_rdata == SS_FREE);
        last       = (scan_reg == LAST_SLOT);
        done       = 1'b0;

        if (state_reg == S_EXEC) begin
            done = 1'b1;
            case (op_reg)
                OP_TICK: begin
                    if (run_reg == '0) begin
                        disp = nonempty;
                    end else begin
                        slice_next = dec;
                        if (dec == '0) begin
                            disp    = 1'b1;
                            requeue = 1'b1;
                        end
                    end
                end
                OP_YIELD: begin
                    disp    = 1'b1;
                    requeue = 1'b1;
                end
                OP_EXIT: begin
                    if (run_reg == '0) begin
                        res_next.status = STS_REFUSED;
                    end else begin
                        st_we   = 1'b1;
                        disp    = 1'b1;
                        has_old = 1'b0;
                    end
                end
                OP_BLOCK: begin
                    if (run_reg == '0) begin
                        res_next.status = STS_REFUSED;
                    end else begin
                        st_we    = 1'b1;
                        st_wdata = SS_BLOCKED;
                        disp     = 1'b1;
                    end
                end
                OP_UNBLOCK: begin
                    if (tgt_ok_reg && st_rdata == SS_BLOCKED) begin
                        st_we     = 1'b1;
                        st_waddr  = SW'(tgt_reg);
                        st_wdata  = SS_READY;
                        fctl.push = 1'b1;
                        push_slot = SW'(tgt_reg);
                    end else begin
                        res_next.status = STS_REFUSED;
                    end
                end
                default: begin
                    res_next.status = STS_REFUSED;
                end
            endcase

            // dispatch: pop head or fall back to idle, requeue a preempted task
            if (disp) begin
                fctl.pop = nonempty;
                if (!(has_old && next_slot == run_reg)) begin
                    run_next   = next_slot;
                    slice_next = slice_ticks_reg;
                    if (requeue && run_reg != '0) begin
                        fctl.push = 1'b1;
                        push_slot = run_reg;
                    end
                end
            end
        end else if (state_reg == S_SCAN) begin
            // free-slot search, one slot per cycle
            done = found || last;
            if (found) begin
                st_we             = 1'b1;
                st_waddr          = scan_reg;
                st_wdata          = SS_READY;
                fctl.push         = 1'b1;
                push_slot         = scan_reg;
                res_next.new_slot = 4'(scan_reg);
                res_next.new_id   = id_reg;
                id_next           = id_reg + 16'd1;
            end else if (last) begin
                res_next.status = STS_NO_SLOT;
            end
        end

        res_next.prev_slot = 4'(run_reg);
        res_next.run_slot  = 4'(run_next);
        res_next.switched  = (run_next != run_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    state_next = (opcode_t'(s_tdata[2:0]) == OP_CREATE) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: state_next = S_OUT;
            S_SCAN: begin
                if (done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg     <= opcode_t'(s_tdata[2:0]);
            tgt_reg    <= s_tdata[6:3];
            tgt_ok_reg <= (32'(s_tdata[6:3]) < TASK_SLOTS);
        end
        if (done) begin
            res_reg <= res_next;
        end
        if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
            m_data_reg <= res_reg;
        end
    end

    // control state and scheduler registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            run_reg         <= '0;
            slice_reg       <= '0;
            id_reg          <= ID_RESET;
            slice_ticks_reg <= SLICE_RESET;
            scan_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                slice_ticks_reg <= cfg_data;
            end
            if (done) begin
                run_reg   <= run_next;
                slice_reg <= slice_next;
                id_reg    <= id_next;
            end
            if (s_xfer) begin
                scan_reg <= SW'(1);
            end else if (state_reg == S_SCAN) begin
                scan_reg <= scan_reg + SW'(1);
            end
            // output register frees on a result transfer, loads from S_OUT
            if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end
endmodule

>>> hw/rtl/rrts_checker.sv
// port-level checks of the round-robin task scheduler, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module rrts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    `RRTS_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `RRTS_ASSERT_IMP(a_status, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3, "status code out of range")
    `RRTS_ASSERT_IMP(a_switch, aclk, aresetn, m_tvalid, m_tdata[2] == (m_tdata[6:3] != m_tdata[10:7]), "switched flag disagrees with slots")
    `RRTS_ASSERT_IMP(a_create, aclk, aresetn, m_tvalid && m_tdata[14:11] != 4'd0, m_tdata[1:0] == 2'd0 && !m_tdata[2], "new slot on a failed event or with a switch")
endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);
